/* rtl/tsw_pkg.sv */
package tsw_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned SizeW = 9;
  localparam int unsigned CoordW = 16;
  // remainder unit: a load step, then one quotient bit per cycle
  localparam int unsigned RemSteps = CoordW + 1;
  localparam int unsigned RemCntW = $clog2(RemSteps + 1);

  localparam logic [2:0] CfgWidth   = 3'd0;
  localparam logic [2:0] CfgHeight  = 3'd1;
  localparam logic [2:0] CfgChans   = 3'd2;
  localparam logic [2:0] CfgWrapX   = 3'd3;
  localparam logic [2:0] CfgWrapY   = 3'd4;
  localparam logic [2:0] CfgBorder  = 3'd5;

  localparam logic [1:0] WrapClamp    = 2'd0;
  localparam logic [1:0] WrapPeriodic = 2'd1;

  localparam logic FuncWrite  = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM_X,
    ST_REM_Y,
    ST_ACCESS,
    ST_READ,
    ST_OUT
  } tsw_state_e;

  typedef struct packed {
    logic load;      // capture input item
    logic rem_start; // start remainder on current axis
    logic rem_axis;  // 0 x, 1 y
    logic mem_go;    // perform write or read
    logic result;    // latch result
  } tsw_cmd_t;

  typedef struct packed {
    logic is_write;
    logic need_rem_x;
    logic need_rem_y;
    logic rem_done;
  } tsw_sts_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       used_border;
    logic       write_rejected;
  } tsw_result_t;

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] r,
                                                 input logic [SizeW-1:0] mx);
    if (r == '0) return SizeW'(1);
    if (r > mx)  return mx;
    return r;
  endfunction

endpackage

/* rtl/tsw_if.sv */
interface tsw_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [31:0] texel_in;
  modport source (output valid, func, coord_x, coord_y, texel_in, input ready);
  modport sink   (input valid, func, coord_x, coord_y, texel_in, output ready);
endinterface

interface tsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       used_border;
  logic       write_rejected;
  modport source (output valid, red, green, blue, alpha, used_border, write_rejected,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, used_border, write_rejected,
                  output ready);
endinterface

interface tsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tsw_ram.sv */
module tsw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         bmask_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= (mem_q[addr_i] & ~bmask_i) | (wdata_i & bmask_i);
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

/* rtl/tsw_ctrl.sv */
module tsw_ctrl import tsw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  tsw_sts_t sts_i,
  output tsw_cmd_t cmd_o
);
  tsw_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_REM_X;
      ST_REM_X: begin
        if (sts_i.is_write || !sts_i.need_rem_x || sts_i.rem_done) begin
          state_d = ST_REM_Y;
        end
      end
      ST_REM_Y: begin
        if (sts_i.is_write || !sts_i.need_rem_y || sts_i.rem_done) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: state_d = ST_READ;
      ST_READ:   state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.rem_start = in_valid_i;
      end
      ST_REM_X: begin
        cmd_o.rem_start = sts_i.rem_done || !sts_i.need_rem_x;
      end
      ST_REM_Y:  cmd_o.rem_axis = 1'b1;
      ST_ACCESS: cmd_o.mem_go = 1'b1;
      ST_READ:   cmd_o.result = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

/* rtl/tsw_dp.sv */
module tsw_dp import tsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsw_cmd_t          cmd_i,
  output tsw_sts_t          sts_o,
  input  logic              func_i,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic [31:0]       texel_in_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output tsw_result_t       result_o
);
  localparam logic [SizeW-1:0] MaxW = SizeW'(MaxWidth);
  localparam logic [SizeW-1:0] MaxH = SizeW'(MaxHeight);

  // configuration registers
  logic [SizeW-1:0] width_q, height_q;
  logic [2:0]       chans_q;
  logic [1:0]       wrap_x_q, wrap_y_q;
  logic [31:0]      border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(256);
      height_q <= SizeW'(256);
      chans_q  <= 3'd3;
      wrap_x_q <= WrapPeriodic;
      wrap_y_q <= WrapPeriodic;
      border_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgHeight: height_q <= cfg_data_i[SizeW-1:0];
        CfgChans:  chans_q  <= cfg_data_i[2:0];
        CfgWrapX:  wrap_x_q <= cfg_data_i[1:0];
        CfgWrapY:  wrap_y_q <= cfg_data_i[1:0];
        CfgBorder: border_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SizeW-1:0] w_eff, h_eff;
  assign w_eff = eff_size(width_q, MaxW);
  assign h_eff = eff_size(height_q, MaxH);

  // captured item
  logic              func_q;
  logic [CoordW-1:0] cx_q, cy_q;
  logic [31:0]       texel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      cx_q    <= coord_x_i;
      cy_q    <= coord_y_i;
      texel_q <= texel_in_i;
    end
  end

  // per-axis classification
  logic x_neg, y_neg, x_in, y_in;
  assign x_neg = cx_q[CoordW-1];
  assign y_neg = cy_q[CoordW-1];
  assign x_in  = !x_neg && (cx_q < CoordW'(w_eff));
  assign y_in  = !y_neg && (cy_q < CoordW'(h_eff));

  // restoring remainder on magnitude, one bit per cycle
  logic [CoordW-1:0]  rem_q, quo_q;
  logic [RemCntW-1:0] cnt_q;
  logic               busy_q;
  logic [CoordW-1:0]  src, mag;
  logic [SizeW-1:0]   dsz;
  logic [CoordW:0]    trial;
  logic [CoordW-1:0]  rx_q, ry_q;

  assign src = cmd_i.rem_axis ? cy_q : cx_q;
  assign mag = src[CoordW-1] ? (~src + 1'b1) : src;
  assign dsz = cmd_i.rem_axis ? h_eff : w_eff;
  assign trial = {rem_q, quo_q[CoordW-1]} - (CoordW+1)'(dsz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.rem_start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && cnt_q != RemCntW'(RemSteps)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_start) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q && cnt_q == '0) begin
      quo_q <= mag;
    end else if (busy_q && cnt_q != RemCntW'(RemSteps)) begin
      if (!trial[CoordW]) rem_q <= trial[CoordW-1:0];
      else                rem_q <= {rem_q[CoordW-2:0], quo_q[CoordW-1]};
      quo_q <= {quo_q[CoordW-2:0], 1'b0};
    end
  end

  logic rem_done;
  // a load step plus RemSteps-1 shifts, finishing at count RemSteps
  assign rem_done = busy_q && cnt_q == RemCntW'(RemSteps);

  // fold sign back: negative nonzero remainder becomes size - r
  logic [CoordW-1:0] rem_fix;
  assign rem_fix = (src[CoordW-1] && rem_q != '0) ? (CoordW'(dsz) - rem_q) : rem_q;

  always_ff @(posedge clk_i) begin
    if (rem_done && !cmd_i.rem_axis) rx_q <= rem_fix;
    if (rem_done &&  cmd_i.rem_axis) ry_q <= rem_fix;
  end

  assign sts_o.is_write   = (func_q == FuncWrite);
  assign sts_o.need_rem_x = !x_in && wrap_x_q == WrapPeriodic;
  assign sts_o.need_rem_y = !y_in && wrap_y_q == WrapPeriodic;
  assign sts_o.rem_done   = rem_done;

  // final coordinates and border decision
  logic [XW-1:0] fx;
  logic [YW-1:0] fy;
  logic          bord;
  always_comb begin
    bord = 1'b0;
    if (x_in)                        fx = cx_q[XW-1:0];
    else if (wrap_x_q == WrapClamp)  fx = x_neg ? '0 : XW'(w_eff - 1'b1);
    else if (wrap_x_q == WrapPeriodic) fx = rx_q[XW-1:0];
    else begin fx = '0; bord = 1'b1; end
    if (y_in)                        fy = cy_q[YW-1:0];
    else if (wrap_y_q == WrapClamp)  fy = y_neg ? '0 : YW'(h_eff - 1'b1);
    else if (wrap_y_q == WrapPeriodic) fy = ry_q[YW-1:0];
    else begin fy = '0; bord = 1'b1; end
  end

  logic chans_ok, do_write, rejected;
  logic [31:0] bmask;
  assign chans_ok = chans_q >= 3'd1 && chans_q <= 3'd4;
  assign rejected = !(x_in && y_in);
  assign do_write = cmd_i.mem_go && sts_o.is_write && !rejected && chans_ok;
  always_comb begin
    bmask = '0;
    for (int c = 0; c < 4; c++) begin
      if (3'(c) < chans_q) bmask[8*c +: 8] = 8'hFF;
    end
  end

  logic [AW-1:0] addr;
  logic [31:0]   rdata;
  assign addr = sts_o.is_write ? {cy_q[YW-1:0], cx_q[XW-1:0]} : {fy, fx};

  tsw_ram #(.Width(32), .Depth(MaxWidth * MaxHeight)) u_ram (
    .clk_i,
    .we_i    (do_write),
    .bmask_i (bmask),
    .addr_i  (addr),
    .wdata_i (texel_q),
    .re_i    (cmd_i.mem_go && !sts_o.is_write),
    .rdata_o (rdata)
  );

  // result register
  logic rej_q, bord_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_go) begin
      rej_q  <= sts_o.is_write && rejected;
      bord_q <= !sts_o.is_write && bord;
    end
  end

  // channel expansion of the read word, or the border color
  tsw_result_t res_d;
  always_comb begin
    res_d = '0;
    res_d.write_rejected = rej_q;
    if (!sts_o.is_write) begin
      if (bord_q) begin
        res_d.red   = border_q[7:0];
        res_d.green = border_q[15:8];
        res_d.blue  = border_q[23:16];
        res_d.alpha = border_q[31:24];
        res_d.used_border = 1'b1;
      end else begin
        res_d.alpha = 8'hFF;
        case (chans_q)
          3'd1: begin
            res_d.red = rdata[7:0];
            res_d.green = rdata[7:0];
            res_d.blue = rdata[7:0];
          end
          3'd2: begin
            res_d.red = rdata[7:0];
            res_d.green = rdata[15:8];
          end
          3'd3: begin
            res_d.red = rdata[7:0];
            res_d.green = rdata[15:8];
            res_d.blue = rdata[23:16];
          end
          3'd4: begin
            res_d.red = rdata[7:0];
            res_d.green = rdata[15:8];
            res_d.blue = rdata[23:16];
            res_d.alpha = rdata[31:24];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      result_o <= res_d;
    end
  end
endmodule

/* rtl/texel_store_wrap_sampler.sv */
// Sequence: from input transfer through ST_REM_X, ST_REM_Y, ST_ACCESS, ST_READ
// and ST_OUT; a remainder runs, one bit a cycle, for each periodic axis whose
// sample coordinate lies outside. One item at a time; next input taken the
// cycle after the result transfer.
// Reset (rst_ni, async low) returns the controller to idle and loads the register
// defaults; texel memory is not cleared and is undefined until written.
module texel_store_wrap_sampler import tsw_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  tsw_in_if.sink    in_if,
  tsw_out_if.source out_if,
  tsw_cfg_if.sink   cfg_if
);
  tsw_cmd_t    cmd;
  tsw_sts_t    sts;
  tsw_result_t res;

  assign cfg_if.ready = 1'b1;

  tsw_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsw_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (in_if.func),
    .coord_x_i   (in_if.coord_x),
    .coord_y_i   (in_if.coord_y),
    .texel_in_i  (in_if.texel_in),
    .cfg_we_i    (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .result_o    (res)
  );

  assign out_if.red            = res.red;
  assign out_if.green          = res.green;
  assign out_if.blue           = res.blue;
  assign out_if.alpha          = res.alpha;
  assign out_if.used_border    = res.used_border;
  assign out_if.write_rejected = res.write_rejected;
endmodule

/* dv/tsw_tb_if.sv */
// Channel interfaces come from the RTL file set; this file holds the
// testbench-side record of one sampler request.
package tsw_tb_pkg;

  typedef struct {
    logic        func;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [31:0] texel_in;
  } tex_req_t;

endpackage

/* dv/tb.sv */
module tb;
  import tsw_pkg::*;
  import tsw_tb_pkg::*;

  localparam logic FuncSample = 1'b1;
  localparam logic [1:0] WrapBorder = 2'd2;
  localparam logic [1:0] WrapOdd    = 2'd3;

  logic clk_i;
  logic rst_ni;

  tsw_in_if  in_ch();
  tsw_out_if out_ch();
  tsw_cfg_if cfg_ch();

  texel_store_wrap_sampler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // Shadow state of the block
  logic [31:0] texel_shadow [int];
  logic [8:0]  sh_width, sh_height;
  logic [2:0]  sh_chans;
  logic [1:0]  sh_wrap_x, sh_wrap_y;
  logic [31:0] sh_border;

  tsw_result_t sample_fifo [$];
  int mismatches;
  int results_seen;
  int idle_pct_in, stall_pct_out;
  bit hold_out;
  int hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("texel_store_wrap_sampler verification failed");
    $finish;
  end

  function automatic int clip_size(logic [8:0] r, int mx);
    if (r == 0) return 1;
    if (r > mx) return mx;
    return int'(r);
  endfunction

  // Maps one axis; -1 selects the border color
  function automatic int map_axis(int c, int n, logic [1:0] mode);
    int r;
    if (c >= 0 && c < n) return c;
    if (mode == WrapClamp) return (c < 0) ? 0 : n - 1;
    if (mode == WrapPeriodic) begin
      r = c % n;
      if (r < 0) r += n;
      return r;
    end
    return -1;
  endfunction

  // Predict result of one request and update the texel shadow
  function automatic tsw_result_t predict_texel(tex_req_t rq);
    tsw_result_t res;
    int w, h, x, y, adr;
    logic [31:0] mask, word;
    res = '0;
    w = clip_size(sh_width, MaxWidth);
    h = clip_size(sh_height, MaxHeight);
    x = $signed(rq.coord_x);
    y = $signed(rq.coord_y);
    if (rq.func == FuncWrite) begin
      if (x < 0 || x >= w || y < 0 || y >= h) res.write_rejected = 1'b1;
      else if (sh_chans >= 1 && sh_chans <= 4) begin
        adr = y * MaxWidth + x;
        mask = '0;
        for (int c = 0; c < sh_chans; c++) mask |= 32'hFF << (8 * c);
        word = texel_shadow.exists(adr) ? texel_shadow[adr] : '0;
        texel_shadow[adr] = (word & ~mask) | (rq.texel_in & mask);
      end
    end else begin
      x = map_axis(x, w, sh_wrap_x);
      if (x >= 0) y = map_axis(y, h, sh_wrap_y);
      if (x < 0 || y < 0) begin
        res.used_border = 1'b1;
        {res.alpha, res.blue, res.green, res.red} = sh_border;
      end else begin
        adr = y * MaxWidth + x;
        word = texel_shadow.exists(adr) ? texel_shadow[adr] : '0;
        res.alpha = 8'hFF;
        case (sh_chans)
          3'd1: begin
            res.red = word[7:0]; res.green = word[7:0]; res.blue = word[7:0];
          end
          3'd2: {res.green, res.red} = word[15:0];
          3'd3: {res.blue, res.green, res.red} = word[23:0];
          3'd4: {res.alpha, res.blue, res.green, res.red} = word;
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  // False only for a sample whose texel word matters and was never written
  function automatic bit sample_safe(tex_req_t rq);
    int w, h, x, y;
    w = clip_size(sh_width, MaxWidth);
    h = clip_size(sh_height, MaxHeight);
    if (rq.func == FuncWrite) return 1'b1;
    if (sh_chans < 3'd1 || sh_chans > 3'd4) return 1'b1;
    x = map_axis($signed(rq.coord_x), w, sh_wrap_x);
    if (x < 0) return 1'b1;
    y = map_axis($signed(rq.coord_y), h, sh_wrap_y);
    if (y < 0) return 1'b1;
    return texel_shadow.exists(y * MaxWidth + x);
  endfunction

  // Send one request; unsafe samples are skipped
  task automatic send_texel(tex_req_t rq);
    if (!sample_safe(rq)) return;
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct_in) @(posedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= rq.func;
    in_ch.coord_x  <= rq.coord_x;
    in_ch.coord_y  <= rq.coord_y;
    in_ch.texel_in <= rq.texel_in;
    do @(posedge clk_i); while (!in_ch.ready);
    sample_fifo.push_back(predict_texel(rq));
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_req(logic f, int x, int y, logic [31:0] d);
    tex_req_t rq;
    rq.func = f;
    rq.coord_x = 16'(x);
    rq.coord_y = 16'(y);
    rq.texel_in = d;
    send_texel(rq);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (sample_fifo.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgWidth:  sh_width  = val[8:0];
      CfgHeight: sh_height = val[8:0];
      CfgChans:  sh_chans  = val[2:0];
      CfgWrapX:  sh_wrap_x = val[1:0];
      CfgWrapY:  sh_wrap_y = val[1:0];
      CfgBorder: sh_border = val;
      default: ;
    endcase
  endtask

  task automatic set_image(int w, int h, int ch, logic [1:0] mx, logic [1:0] my,
                           logic [31:0] bc);
    drain_results();
    write_reg(CfgWidth, 32'(w));
    write_reg(CfgHeight, 32'(h));
    write_reg(CfgChans, 32'(ch));
    write_reg(CfgWrapX, 32'(mx));
    write_reg(CfgWrapY, 32'(my));
    write_reg(CfgBorder, bc);
  endtask

  // Fill the whole current image so every sample hits written texels
  task automatic fill_image(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) send_req(FuncWrite, x, y, $urandom());
  endtask

  function automatic int rand_coord(int n);
    case ($urandom_range(5))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(1) ? 32767 : -32768;
      2: return n + $urandom_range(40);
      3: return -1 - $urandom_range(40);
      default: return $urandom_range(n - 1);
    endcase
  endfunction

  // Receiver: ready and result checks
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (sample_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          tsw_result_t exp_r;
          exp_r = sample_fifo.pop_front();
          if (out_ch.red !== exp_r.red || out_ch.green !== exp_r.green ||
              out_ch.blue !== exp_r.blue || out_ch.alpha !== exp_r.alpha ||
              out_ch.used_border !== exp_r.used_border ||
              out_ch.write_rejected !== exp_r.write_rejected) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp r%h g%h b%h a%h bd%b rj%b got r%h g%h b%h a%h bd%b rj%b",
                       exp_r.red, exp_r.green, exp_r.blue, exp_r.alpha,
                       exp_r.used_border, exp_r.write_rejected,
                       out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                       out_ch.used_border, out_ch.write_rejected);
          end
        end
      end
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        hold_cycles++;
      end else out_ch.ready <= ($urandom_range(99) >= stall_pct_out);
    end
  end

  // Long hold-off of the receiver while requests keep coming
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_out = 1'b1;
    fork
      for (int i = 0; i < 6; i++) send_req(FuncWrite, i, 0, $urandom());
      begin
        wait (hold_cycles >= 200);
        hold_out = 1'b0;
      end
    join
    drain_results();
  endtask

  task automatic test_directed();
    set_image(4, 3, 4, WrapClamp, WrapClamp, 32'hA1B2C3D4);
    fill_image(4, 3);
    send_req(FuncWrite, 4, 0, 32'h1);
    send_req(FuncWrite, 0, -1, 32'h1);
    send_req(FuncWrite, -32768, 32767, 32'hFFFFFFFF);
    send_req(FuncSample, -32768, 32767, 0);
    send_req(FuncSample, 32767, -32768, 0);
    send_req(FuncSample, 3, 2, 0);
    set_image(4, 3, 1, WrapPeriodic, WrapPeriodic, 32'h0);
    send_req(FuncSample, -5, 7, 0);
    send_req(FuncSample, -32768, 32767, 0);
    set_image(4, 3, 2, WrapBorder, WrapOdd, 32'hDEADBEEF);
    send_req(FuncSample, -1, 0, 0);
    send_req(FuncSample, 0, 3, 0);
    send_req(FuncSample, 1, 1, 0);
    set_image(4, 3, 3, WrapOdd, WrapClamp, 32'h01020304);
    send_req(FuncWrite, 1, 1, 32'hFFFFFFFF);
    send_req(FuncSample, 4, 0, 0);
    send_req(FuncSample, 1, 1, 0);
    set_image(4, 3, 0, WrapClamp, WrapClamp, 0);
    send_req(FuncWrite, 2, 2, 32'h55555555);
    send_req(FuncSample, 2, 2, 0);
    set_image(0, 511, 7, WrapPeriodic, WrapPeriodic, 0);
    send_req(FuncWrite, 0, 0, 32'h12345678);
    send_req(FuncSample, 9, 300, 0);
    send_req(FuncWrite, 1, 0, 32'h0);
    drain_results();
  endtask

  task automatic test_random(int n);
    int w, h;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 70; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 70; end
        default: begin idle_pct_in = 12; stall_pct_out = 12; end
      endcase
      w = (p == 3) ? 256 : $urandom_range(1, 9);
      h = (p == 3) ? 1 : $urandom_range(1, 7);
      set_image(w, h, $urandom_range(7), 2'($urandom_range(3)), 2'($urandom_range(3)),
                $urandom());
      if (p != 3) fill_image(w, h);
      else for (int i = 0; i < 12; i++) send_req(FuncWrite, $urandom_range(255), 0, $urandom());
      for (int i = 0; i < n / 4; i++)
        send_req($urandom_range(3) != 0 ? FuncSample : FuncWrite,
                 rand_coord(w), rand_coord(h), $urandom());
    end
    idle_pct_in = 0;
    stall_pct_out = 0;
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FuncWrite;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.texel_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgWidth;
    cfg_ch.data <= '0;
    sh_width = 9'd256; sh_height = 9'd256; sh_chans = 3'd3;
    sh_wrap_x = WrapPeriodic; sh_wrap_y = WrapPeriodic; sh_border = '0;
    mismatches = 0; results_seen = 0; hold_out = 1'b0;
    idle_pct_in = 0; stall_pct_out = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(440);
    drain_results();
    $display("covered all wrap modes, channel counts, rejected writes and saturated sizes");
    $display("%0d results checked under idle, stall and hold-off phases", results_seen);
    if (mismatches == 0 && sample_fifo.size() == 0)
      $display("texel_store_wrap_sampler verification clean");
    else
      $display("texel_store_wrap_sampler verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/tsw_pkg.sv
rtl/tsw_if.sv
rtl/tsw_ram.sv
rtl/tsw_ctrl.sv
rtl/tsw_dp.sv
rtl/texel_store_wrap_sampler.sv
dv/tsw_tb_if.sv
dv/tb.sv
